// ===== hdl/cahist_pkg.sv =====
// Shared constants, codes and item types for the channel argmax cell histogram.
// Used by the channel interfaces, the top level and the testbench. No dependencies.
`default_nettype none

package cahist_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_CHANNELS  = 16;
    localparam int DEF_MAX_GRID_SIDE = 8;
    localparam int DEF_MAX_EXTENT    = 1024;

    // Field widths fixed by the item formats.
    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 4;
    localparam int POS_W     = 10;
    localparam int BIN_W     = 10;
    localparam int COUNT_W   = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Request function codes.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Result kind codes.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 3'd4;

    // Register values after reset.
    localparam logic [4:0]  RST_NUM_CHANNELS = 5'd16;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd64;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd64;
    localparam logic        RST_GRID_MODE    = 1'b0;
    localparam logic [3:0]  RST_BLOCK_SIZE   = 4'd2;

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          channel;
        logic [POS_W-1:0]           row;
        logic [POS_W-1:0]           col;
        logic [BIN_W-1:0]           bin_index;
    } req_item_t;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] max_value;
        logic [CHAN_W-1:0]          argmax;
        logic [COUNT_W-1:0]         bin_count;
    } rsp_item_t;

endpackage

`default_nettype wire

// ===== hdl/cahist_if.sv =====
// Valid/ready channel interfaces: request items, result items and register writes.
// Depends on cahist_pkg for the item types and field widths.
`default_nettype none

interface cahist_req_if;
    import cahist_pkg::*;
    logic      valid;
    logic      ready;
    req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cahist_rsp_if;
    import cahist_pkg::*;
    logic      valid;
    logic      ready;
    rsp_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cahist_cfg_if;
    import cahist_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== hdl/channel_argmax_cell_histogram_core.sv =====
// Top level: per-pixel channel argmax and a cell/channel histogram with read-and-clear.
// Depends on cahist_pkg, the channel interfaces in cahist_if.sv and cahist_div.
//
//   Channel  Modport  Payload                                     Accepted when
//   req      sink     func, sample, channel, row, col, bin_index  req.valid && req.ready
//   rsp      source   kind, max_value, argmax, bin_count          rsp.valid && rsp.ready
//   cfg      sink     index, wdata                                cfg.valid (always ready)
//
// A sample that is not the pixel's last channel is taken in the idle state. The last channel
// runs four divisions on the shared divider and then a histogram read-modify-write;
// a bin read-out reads its bin and writes it back as zero. After reset a clearing pass
// zeroes all HIST_DEPTH bins of the histogram before req opens.
// A result waits in the output register; only the next result-producing item stalls on it.
`default_nettype none

module channel_argmax_cell_histogram_core #(
    parameter int MAX_CHANNELS  = cahist_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_GRID_SIDE = cahist_pkg::DEF_MAX_GRID_SIDE,
    parameter int MAX_EXTENT    = cahist_pkg::DEF_MAX_EXTENT
) (
    input  logic         clk,
    input  logic         rst_n,
    cahist_req_if.sink   req,
    cahist_rsp_if.source rsp,
    cahist_cfg_if.sink   cfg
);
    import cahist_pkg::*;

    localparam int HIST_DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE * MAX_CHANNELS;
    localparam int AW         = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int IDX_RAW_W  = $clog2(HIST_DEPTH + 16);
    localparam int IDX_W      = (IDX_RAW_W > BIN_W) ? IDX_RAW_W : BIN_W;
    localparam int EXT_RAW_W  = $clog2(MAX_EXTENT) + 1;
    localparam int DIV_W      = (EXT_RAW_W > POS_W) ? EXT_RAW_W : POS_W;
    localparam int NW         = $clog2(MAX_CHANNELS + 1);
    localparam int SW         = $clog2(MAX_GRID_SIDE + 1);
    localparam int CELLW      = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE + 1);
    localparam int P2MAX      = 1 << ($clog2(MAX_GRID_SIDE + 1) - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_IDX   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    localparam logic [1:0] PH_SIZE_H = 2'd0;
    localparam logic [1:0] PH_ROW    = 2'd1;
    localparam logic [1:0] PH_SIZE_W = 2'd2;
    localparam logic [1:0] PH_COL    = 2'd3;

    // Configuration registers
    logic [4:0]  num_channels_reg;
    logic [10:0] image_height_reg;
    logic [10:0] image_width_reg;
    logic        grid_mode_reg;
    logic [3:0]  block_size_reg;

    // Control and running state
    logic [2:0]                 state_reg, state_next;
    logic [1:0]                 phase_reg, phase_next;
    logic                       div_go_reg, div_go_next;
    logic [AW-1:0]              clr_reg, clr_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       func_reg, func_next;
    logic signed [SAMPLE_W-1:0] running_max_reg, running_max_next;
    logic [CHAN_W-1:0]          running_argmax_reg, running_argmax_next;

    // Payload registers
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [POS_W-1:0]   row_reg, row_next;
    logic [POS_W-1:0]   col_reg, col_next;
    logic [DIV_W-1:0]   size_reg, size_next;
    logic [SW-1:0]      cy_reg, cy_next;
    logic [CELLW-1:0]   cell_reg, cell_next;
    logic [COUNT_W-1:0] rd_data_reg;
    rsp_item_t          out_reg;

    logic [COUNT_W-1:0] hist_mem [HIST_DEPTH];

    // Derived configuration
    logic [NW-1:0]    n_ch;
    logic [SW-1:0]    side;
    logic [15:0]      pow_side;
    logic [3:0]       pow_exp;
    logic [DIV_W-1:0] ext_h;
    logic [DIV_W-1:0] ext_w;

    // Datapath
    logic             ch_in_range;
    logic             ch_last;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [SW-1:0]    quo_sat;
    logic             idx_ok;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic             out_load;

    always_comb
    begin
        if (num_channels_reg == '0)
            n_ch = NW'(1);
        else if (int'(num_channels_reg) > MAX_CHANNELS)
            n_ch = NW'(MAX_CHANNELS);
        else
            n_ch = NW'(num_channels_reg);

        pow_exp  = (block_size_reg == '0) ? 4'd0 : block_size_reg - 4'd1;
        pow_side = 16'd1 << pow_exp;
        if (grid_mode_reg == 1'b0)
        begin
            if (block_size_reg == '0)
                side = SW'(1);
            else if (int'(block_size_reg) > MAX_GRID_SIDE)
                side = SW'(MAX_GRID_SIDE);
            else
                side = SW'(block_size_reg);
        end
        else
        begin
            // Doubling stops at the largest power of two that fits the grid.
            if (int'(pow_side) > P2MAX)
                side = SW'(P2MAX);
            else
                side = SW'(pow_side);
        end

        if (image_height_reg == '0)
            ext_h = DIV_W'(1);
        else if (int'(image_height_reg) > MAX_EXTENT)
            ext_h = DIV_W'(MAX_EXTENT);
        else
            ext_h = DIV_W'(image_height_reg);

        if (image_width_reg == '0)
            ext_w = DIV_W'(1);
        else if (int'(image_width_reg) > MAX_EXTENT)
            ext_w = DIV_W'(MAX_EXTENT);
        else
            ext_w = DIV_W'(image_width_reg);
    end

    // Operands of the shared divider follow the current phase.
    always_comb
    begin
        case (phase_reg)
            PH_SIZE_H:
            begin
                div_dividend = ext_h + DIV_W'(side) - DIV_W'(1);
                div_divisor  = DIV_W'(side);
            end
            PH_ROW:
            begin
                div_dividend = DIV_W'(row_reg);
                div_divisor  = size_reg;
            end
            PH_SIZE_W:
            begin
                div_dividend = ext_w + DIV_W'(side) - DIV_W'(1);
                div_divisor  = DIV_W'(side);
            end
            default:
            begin
                div_dividend = DIV_W'(col_reg);
                div_divisor  = size_reg;
            end
        endcase
    end

    cahist_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_sat     = (div_quo >= DIV_W'(side)) ? side - SW'(1) : SW'(div_quo);
    assign ch_in_range = int'(req.data.channel) < int'(n_ch);
    assign ch_last     = int'(req.data.channel) == int'(n_ch) - 1;
    assign idx_ok      = idx_reg < IDX_W'(HIST_DEPTH);
    assign mem_waddr   = (state_reg == S_CLEAR) ? clr_reg : idx_reg[AW-1:0];

    always_comb
    begin
        if (state_reg == S_CLEAR || func_reg == FUNC_READ)
            mem_wdata = '0;
        else if (rd_data_reg == COUNT_MAX)
            mem_wdata = rd_data_reg;
        else
            mem_wdata = rd_data_reg + COUNT_W'(1);
    end

    always_comb
    begin
        state_next          = state_reg;
        phase_next          = phase_reg;
        div_go_next         = 1'b0;
        clr_next            = clr_reg;
        func_next           = func_reg;
        running_max_next    = running_max_reg;
        running_argmax_next = running_argmax_reg;
        idx_next            = idx_reg;
        row_next            = row_reg;
        col_next            = col_reg;
        size_next           = size_reg;
        cy_next             = cy_reg;
        cell_next           = cell_reg;
        mem_we              = 1'b0;
        out_load            = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_reg == AW'(HIST_DEPTH - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.data.func == FUNC_READ)
                    begin
                        func_next  = FUNC_READ;
                        idx_next   = IDX_W'(req.data.bin_index);
                        state_next = S_READ;
                    end
                    else if (ch_in_range)
                    begin
                        if (req.data.channel == '0)
                        begin
                            running_max_next    = req.data.sample;
                            running_argmax_next = '0;
                        end
                        else if (req.data.sample > running_max_reg)
                        begin
                            running_max_next    = req.data.sample;
                            running_argmax_next = req.data.channel;
                        end
                        if (ch_last)
                        begin
                            // The pixel position is held for the divisions that follow.
                            row_next    = req.data.row;
                            col_next    = req.data.col;
                            func_next   = FUNC_PUSH;
                            phase_next  = PH_SIZE_H;
                            div_go_next = 1'b1;
                            state_next  = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_SIZE_H: size_next = div_quo;
                        PH_ROW:    cy_next   = quo_sat;
                        PH_SIZE_W: size_next = div_quo;
                        default:   cell_next = CELLW'(cy_reg) * CELLW'(side)
                                             + CELLW'(quo_sat);
                    endcase
                    if (phase_reg == PH_COL)
                        state_next = S_IDX;
                    else
                    begin
                        phase_next  = phase_reg + 2'd1;
                        div_go_next = 1'b1;
                    end
                end
            end
            S_IDX:
            begin
                idx_next   = IDX_W'(cell_reg) * IDX_W'(n_ch) + IDX_W'(running_argmax_reg);
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    mem_we     = idx_ok;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            phase_reg          <= PH_SIZE_H;
            div_go_reg         <= 1'b0;
            clr_reg            <= '0;
            out_valid_reg      <= 1'b0;
            func_reg           <= FUNC_PUSH;
            running_max_reg    <= '0;
            running_argmax_reg <= '0;
            num_channels_reg   <= RST_NUM_CHANNELS;
            image_height_reg   <= RST_IMAGE_HEIGHT;
            image_width_reg    <= RST_IMAGE_WIDTH;
            grid_mode_reg      <= RST_GRID_MODE;
            block_size_reg     <= RST_BLOCK_SIZE;
        end
        else
        begin
            state_reg          <= state_next;
            phase_reg          <= phase_next;
            div_go_reg         <= div_go_next;
            clr_reg            <= clr_next;
            out_valid_reg      <= out_valid_next;
            func_reg           <= func_next;
            running_max_reg    <= running_max_next;
            running_argmax_reg <= running_argmax_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_NUM_CHANNELS: num_channels_reg <= cfg.wdata[4:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg.wdata;
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg.wdata;
                    REG_GRID_MODE:    grid_mode_reg    <= cfg.wdata[0];
                    REG_BLOCK_SIZE:   block_size_reg   <= cfg.wdata[3:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        size_reg <= size_next;
        cy_reg   <= cy_next;
        cell_reg <= cell_next;
        if (out_load)
        begin
            out_reg.kind      <= (func_reg == FUNC_READ) ? KIND_BIN : KIND_PIXEL;
            out_reg.max_value <= (func_reg == FUNC_READ) ? '0 : running_max_reg;
            out_reg.argmax    <= (func_reg == FUNC_READ) ? '0 : running_argmax_reg;
            out_reg.bin_count <= (func_reg == FUNC_READ && idx_ok) ? rd_data_reg : '0;
        end
    end

    // Histogram memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= hist_mem[idx_reg[AW-1:0]];
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // The cell number stays inside the grid after coordinate saturation.
    a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDX |-> int'(cell_reg) < int'(side) * int'(side))
        else $error("cell index outside the grid");

    // A counted pixel never wraps a histogram counter to zero.
    a_count_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && state_reg == S_WRITE && func_reg == FUNC_PUSH |-> mem_wdata != '0)
        else $error("histogram counter wrapped");

    // A new result only appears out of the write-back step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg) == S_WRITE)
        else $error("result raised outside write-back");

endmodule

`default_nettype wire

// ===== hdl/cahist_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; shared by the top level for cell sizes and cell coordinates.
`default_nettype none

module cahist_div #(
    parameter int W = 11
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dsr_reg;
    logic [W:0]       trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? W'(trial - {1'b0, dsr_reg}) : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== tb/tb_channel_argmax_cell_histogram_core.sv =====
// Self-checking testbench for channel_argmax_cell_histogram_core: per-pixel argmax results and
// histogram read-outs are checked against a cycle-free predictor kept inside this file.
// Depends on cahist_pkg, the channel interfaces in cahist_if.sv and the core's RTL.

module tb_channel_argmax_cell_histogram_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cahist_pkg::*;

    localparam int MAX_CH         = DEF_MAX_CHANNELS;
    localparam int MAX_SIDE       = DEF_MAX_GRID_SIDE;
    localparam int MAX_EXT        = DEF_MAX_EXTENT;
    localparam int HIST_BINS      = MAX_SIDE * MAX_SIDE * MAX_CH;
    localparam int SETTLE_CYCLES  = 200;
    localparam int END_WAIT_LIMIT = 200000;

    // Register index outside the map; the core must ignore a write to it.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    cahist_req_if req_ch ();
    cahist_rsp_if rsp_ch ();
    cahist_cfg_if cfg_ch ();

    channel_argmax_cell_histogram_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // Predictor state: register copies, running pixel values and the bin counters.
    logic [4:0]                 cfg_nch;
    logic [10:0]                cfg_h;
    logic [10:0]                cfg_w;
    logic                       cfg_mode;
    logic [3:0]                 cfg_bs;
    logic signed [SAMPLE_W-1:0] pixel_max;
    logic [CHAN_W-1:0]          pixel_arg;
    logic [COUNT_W-1:0]         bin_counts [HIST_BINS];
    int                         last_bin;

    rsp_item_t awaited_results [$];
    int        error_count;
    int        send_idle_pct;
    int        rsp_stall_pct;

    function automatic int clamp_to(input int v, input int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int cell_of(input int pos, input int extent, input int side);
        int span;
        span = (clamp_to(extent, MAX_EXT) + side - 1) / side;
        return (pos / span >= side) ? side - 1 : pos / span;
    endfunction

    // Advances the predicted state by one accepted item and queues the result it causes.
    task automatic predict(input req_item_t it);
        rsp_item_t r;
        int        n;
        int        side;
        int        k;
        int        slot;
        r = '0;
        n = clamp_to(cfg_nch, MAX_CH);
        if (it.func == FUNC_READ) begin
            r.kind = KIND_BIN;
            r.bin_count = bin_counts[it.bin_index];
            bin_counts[it.bin_index] = '0;
            awaited_results.push_back(r);
        end
        else if (it.channel < n) begin
            if (it.channel == 0) begin
                pixel_max = $signed(it.sample);
                pixel_arg = '0;
            end
            else if ($signed(it.sample) > pixel_max) begin
                pixel_max = $signed(it.sample);
                pixel_arg = it.channel;
            end
            if (it.channel == n - 1) begin
                if (cfg_mode == 1'b0)
                    side = clamp_to(cfg_bs, MAX_SIDE);
                else
                begin
                    side = 1;
                    for (k = 1; k < cfg_bs; k++)
                        if (side * 2 <= MAX_SIDE)
                            side = side * 2;
                end
                slot = (cell_of(it.row, cfg_h, side) * side + cell_of(it.col, cfg_w, side)) * n
                     + pixel_arg;
                if (bin_counts[slot] != COUNT_MAX)
                    bin_counts[slot] = bin_counts[slot] + 1'b1;
                last_bin = slot;
                r.kind = KIND_PIXEL;
                r.max_value = pixel_max;
                r.argmax = pixel_arg;
                awaited_results.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input rsp_item_t want,
                                   input rsp_item_t got);
        error_count++;
        if (error_count <= 10)
            $display("%s: expected kind %0d max %0d argmax %0d count %0d, %s %0d %s %0d %s %0d %s %0d",
                     what, want.kind, $signed(want.max_value), want.argmax, want.bin_count,
                     "got kind", got.kind, "max", $signed(got.max_value),
                     "argmax", got.argmax, "count", got.bin_count);
    endtask

    // Sends one item. With hold set, the sender first waits until every result has come.
    task automatic send_request(input req_item_t it, input bit hold);
        if (hold || ($urandom_range(99) < send_idle_pct)) begin
            req_ch.valid <= 1'b0;
            if (hold)
                while (awaited_results.size() != 0)
                    @(posedge clk);
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict(it);
    endtask

    function automatic req_item_t random_item();
        req_item_t it;
        it.func      = 1'($urandom_range(1));
        it.sample    = SAMPLE_W'($urandom);
        it.channel   = CHAN_W'($urandom);
        it.row       = POS_W'($urandom);
        it.col       = POS_W'($urandom);
        it.bin_index = BIN_W'($urandom);
        return it;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            // Few distinct values, so that ties are common.
            2, 3, 4: return SAMPLE_W'($urandom_range(4)) - SAMPLE_W'(2);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] value,
                               input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                               input bit hold = 1'b0);
        req_item_t it;
        it = random_item();
        it.func    = FUNC_PUSH;
        it.channel = ch;
        it.sample  = value;
        it.row     = r;
        it.col     = c;
        send_request(it, hold);
    endtask

    task automatic request_bin(input logic [BIN_W-1:0] idx, input bit hold = 1'b0);
        req_item_t it;
        it = random_item();
        it.func      = FUNC_READ;
        it.bin_index = idx;
        send_request(it, hold);
    endtask

    // Lowers valid, waits for all results and lets a pixel still in flight finish.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_NUM_CHANNELS: cfg_nch  = value[4:0];
            REG_IMAGE_HEIGHT: cfg_h    = value[10:0];
            REG_IMAGE_WIDTH:  cfg_w    = value[10:0];
            REG_GRID_MODE:    cfg_mode = value[0];
            REG_BLOCK_SIZE:   cfg_bs   = value[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [4:0] n, input logic [10:0] h, input logic [10:0] w,
                             input logic mode, input logic [3:0] bs, input bit spare = 1'b0);
        wait_idle();
        if (spare)
            write_reg(REG_SPARE, '1);
        write_reg(REG_NUM_CHANNELS, CFG_DAT_W'(n));
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_GRID_MODE, CFG_DAT_W'(mode));
        write_reg(REG_BLOCK_SIZE, CFG_DAT_W'(bs));
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly whole pixels with random content, plus read-outs, cut pixels and stray channels.
    task automatic run_traffic(input int target);
        int               sent;
        int               n;
        int               pick;
        int               ch;
        int               stop;
        int               bsel;
        logic [POS_W-1:0] prow;
        logic [POS_W-1:0] pcol;
        sent = 0;
        while (sent < target) begin
            n = clamp_to(cfg_nch, MAX_CH);
            pick = $urandom_range(99);
            if (pick < 75) begin
                if ($urandom_range(9) == 0) begin
                    prow = POS_W'($urandom);
                    pcol = POS_W'($urandom);
                end
                else
                begin
                    prow = POS_W'($urandom_range(clamp_to(cfg_h, MAX_EXT) - 1));
                    pcol = POS_W'($urandom_range(clamp_to(cfg_w, MAX_EXT) - 1));
                end
                for (ch = 0; ch < n; ch++)
                    push_sample(CHAN_W'(ch), pick_sample(), prow, pcol,
                                $urandom_range(149) == 0);
                sent += n;
            end
            else if (pick < 88) begin
                bsel = ($urandom_range(2) != 0) ? last_bin : $urandom_range(HIST_BINS - 1);
                request_bin(BIN_W'(bsel));
                sent++;
            end
            else if (pick < 94 && n > 1) begin
                // A pixel cut short; the next channel zero starts over.
                stop = $urandom_range(n - 2);
                for (ch = 0; ch <= stop; ch++)
                    push_sample(CHAN_W'(ch), pick_sample(), POS_W'($urandom), POS_W'($urandom));
                sent += stop + 1;
            end
            else
            begin
                ch = $urandom_range(15);
                push_sample(CHAN_W'(ch), pick_sample(), POS_W'($urandom), POS_W'($urandom));
                if (ch < n)
                    sent++;
            end
        end
    endtask

    task automatic test_directed_cases();
        int ch;
        configure(5'd4, 11'd64, 11'd64, 1'b0, 4'd2);
        // All channels equal at the most negative value: channel 0 wins.
        for (ch = 0; ch < 4; ch++)
            push_sample(CHAN_W'(ch), 16'h8000, 10'd0, 10'd0);
        // A tie at the largest value goes to the lower channel; the pixel lies outside the image.
        push_sample(4'd0, 16'd100, 10'd1023, 10'd1023);
        push_sample(4'd1, 16'h7FFF, 10'd1023, 10'd1023);
        push_sample(4'd2, 16'h7FFF, 10'd1023, 10'd1023);
        push_sample(4'd3, 16'd5, 10'd1023, 10'd1023);
        // Read that bin once everything has come back, then again to see it cleared.
        request_bin(BIN_W'(last_bin), 1'b1);
        request_bin(BIN_W'(last_bin));
        // Channels out of order, with a read-out in the middle of the pixel.
        push_sample(4'd0, 16'd10, 10'd3, 10'd40);
        push_sample(4'd2, 16'd50, 10'd3, 10'd40);
        request_bin(10'd0);
        push_sample(4'd1, 16'd60, 10'd3, 10'd40);
        push_sample(4'd3, 16'd0, 10'd3, 10'd40);
        // A fresh channel zero abandons the pixel that was started.
        push_sample(4'd0, 16'd1, 10'd7, 10'd7);
        push_sample(4'd1, 16'd2, 10'd7, 10'd7);
        push_sample(4'd0, -16'sd5, 10'd33, 10'd2);
        push_sample(4'd1, -16'sd6, 10'd33, 10'd2);
        push_sample(4'd2, -16'sd1, 10'd33, 10'd2);
        push_sample(4'd3, -16'sd7, 10'd33, 10'd2);
        // Channels at or beyond the channel count are dropped.
        push_sample(4'd9, 16'h7FFF, 10'd0, 10'd0);
        push_sample(4'd15, 16'h7FFF, 10'd0, 10'd0);
    endtask

    task automatic test_running_state_across_writes();
        configure(5'd4, 11'd64, 11'd64, 1'b0, 4'd2);
        push_sample(4'd0, 16'd300, 10'd0, 10'd0);
        push_sample(4'd1, 16'd400, 10'd0, 10'd0);
        // The half-done pixel must survive the register writes.
        configure(5'd4, 11'd20, 11'd9, 1'b1, 4'd3);
        push_sample(4'd2, 16'd350, 10'd5, 10'd8);
        push_sample(4'd3, 16'd500, 10'd5, 10'd8);
        request_bin(BIN_W'(last_bin), 1'b1);
    endtask

    task automatic test_register_extremes();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        configure(5'd1, 11'd1, 11'd1, 1'b1, 4'd0, 1'b1);
        run_traffic(80);
        configure(5'd16, 11'd1024, 11'd1024, 1'b0, 4'd8);
        run_traffic(80);
        configure(5'd0, 11'd0, 11'd0, 1'b1, 4'd15);
        run_traffic(80);
        configure(5'd31, 11'd2047, 11'd1, 1'b0, 4'd0);
        run_traffic(80);
        configure(5'd5, 11'd1000, 11'd37, 1'b0, 4'd12);
        run_traffic(80);
        configure(5'd2, 11'd3, 11'd1023, 1'b1, 4'd4);
        run_traffic(80);
    endtask

    task automatic test_random_settings();
        int          phase;
        int          k;
        logic [4:0]  n;
        logic [10:0] h;
        logic [10:0] w;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
                default: begin send_idle_pct = 25; rsp_stall_pct = 25; end
            endcase
            for (k = 0; k < 3; k++) begin
                n = 5'(($urandom_range(6) == 0) ? $urandom_range(31) : $urandom_range(16, 1));
                h = 11'(($urandom_range(6) == 0) ? $urandom_range(2047)
                                                 : $urandom_range(1024, 1));
                w = 11'(($urandom_range(6) == 0) ? $urandom_range(2047)
                                                 : $urandom_range(1024, 1));
                configure(n, h, w, 1'($urandom_range(1)), 4'($urandom_range(15)));
                run_traffic(120);
            end
        end
    endtask

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

    always @(posedge clk) begin : check_results
        rsp_item_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0)
                report_mismatch("unexpected result", '0, rsp_ch.data);
            else
            begin
                want = awaited_results.pop_front();
                if (rsp_ch.data.kind !== want.kind || rsp_ch.data.max_value !== want.max_value
                        || rsp_ch.data.argmax !== want.argmax
                        || rsp_ch.data.bin_count !== want.bin_count)
                    report_mismatch("result mismatch", want, rsp_ch.data);
            end
        end
    end

    initial begin
        int waited;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.wdata  = '0;
        cfg_nch       = RST_NUM_CHANNELS;
        cfg_h         = RST_IMAGE_HEIGHT;
        cfg_w         = RST_IMAGE_WIDTH;
        cfg_mode      = RST_GRID_MODE;
        cfg_bs        = RST_BLOCK_SIZE;
        pixel_max     = '0;
        pixel_arg     = '0;
        last_bin      = 0;
        error_count   = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        foreach (bin_counts[i])
            bin_counts[i] = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_running_state_across_writes();
        test_register_extremes();
        test_random_settings();

        req_ch.valid <= 1'b0;
        waited = 0;
        while (awaited_results.size() != 0 && waited < END_WAIT_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (awaited_results.size() != 0) begin
            error_count += awaited_results.size();
            $display("%0d expected results never arrived", awaited_results.size());
        end
        if (error_count == 0)
            $display("tb_channel_argmax_cell_histogram_core: done, clean");
        else
            $display("tb_channel_argmax_cell_histogram_core: done, errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_channel_argmax_cell_histogram_core: done, errors");
        $finish;
    end

endmodule

// ===== channel_argmax_cell_histogram_core.f =====
hdl/cahist_pkg.sv
hdl/cahist_if.sv
hdl/cahist_div.sv
hdl/channel_argmax_cell_histogram_core.sv
tb/tb_channel_argmax_cell_histogram_core.sv
